// ===== src/cbpo_pkg.sv =====
`default_nettype none
package cbpo_pkg;

	// Coordinate width of the box and circle centres.
	localparam int COORD_BITS = 16;
	// Width of the half sizes and of the radius.
	localparam int RAD_BITS = 14;
	// Width of the result coordinates.
	localparam int OUT_BITS = 18;
	// Signed working width for coordinates, distances and push targets.
	localparam int WORK_BITS = (COORD_BITS + 2 > 20) ? COORD_BITS + 2 : 20;

	// Widths used by the exact corner placement.
	localparam int SQ_BITS  = 2 * RAD_BITS + 1;
	localparam int NUM_BITS = 4 * RAD_BITS;
	localparam int PRD_BITS = 3 * RAD_BITS + 1;
	localparam int ACC_BITS = 4 * RAD_BITS + 3;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_RAW    = 4 * COORD_BITS + 3 * RAD_BITS + 4;
	localparam int IN_BITS   = ((IN_RAW + 7) / 8) * 8;
	localparam int OUT_RAW   = 2 * OUT_BITS;
	localparam int OUT_DBITS = ((OUT_RAW + 7) / 8) * 8;

	// Bit positions in the direction mask.
	localparam int DIR_LEFT   = 0;
	localparam int DIR_RIGHT  = 1;
	localparam int DIR_TOP    = 2;
	localparam int DIR_BOTTOM = 3;

	typedef logic signed [WORK_BITS-1:0] work_t;
	typedef logic [RAD_BITS-1:0] rad_t;

	// What the final stage needs to build the result.
	typedef struct packed {
		logic  hit;
		logic  diag;
		logic  right;
		logic  top;
		work_t nx;
		work_t ny;
		work_t bx;
		work_t by;
		rad_t  w;
		rad_t  h;
	} ctx_t;

endpackage
`default_nettype wire

// ===== src/circle_box_push_out_unit.sv =====
`default_nettype none
// Resolves one box/circle overlap per beat. A beat on the slave side carries
// a box (centre and half sizes), a circle (centre and radius) and a four-bit
// mask of allowed push directions; the matching beat on the master side says
// whether the two overlapped and gives the circle centre after it has been
// pushed just outside the box, or the unchanged centre when there was no hit.
// Edge overlaps push along one axis. Corner overlaps place the circle
// diagonally off the corner using an exact integer square-root quotient
// when both sides next to it are allowed, and push along one axis otherwise.
// The unit is a fully pipelined datapath of RAD_BITS + 4 register stages
// (18 at the default widths). A new beat is taken in every cycle while the
// master side accepts.
// The depth is set by the corner placement, which settles one quotient bit
// per stage. Every stage has its own valid bit and back-pressure ripples
// back stage by stage, so empty stages are filled even while a finished
// result waits on the master side. Items are independent; no state links them.
module circle_box_push_out_unit
	import cbpo_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_axis_tvalid,
	output logic                 s_axis_tready,
	// From bit 0 up: box_x, box_y, half_width, half_height, circle_x,
	// circle_y, radius, dir_mask, zero padding.
	input  wire  [IN_BITS-1:0]   s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  wire                  m_axis_tready,
	// From bit 0 up: new_x, new_y, zero padding.
	output logic [OUT_DBITS-1:0] m_axis_tdata,
	// Bit 0: hit.
	output logic                 m_axis_tuser
);

	// Field unpacking of the incoming beat.
	logic signed [COORD_BITS-1:0] in_bx, in_by, in_cx, in_cy;
	rad_t                         in_w, in_h, in_r;
	logic [3:0]                   in_m;

	assign in_bx = s_axis_tdata[0 +: COORD_BITS];
	assign in_by = s_axis_tdata[COORD_BITS +: COORD_BITS];
	assign in_w  = s_axis_tdata[2*COORD_BITS +: RAD_BITS];
	assign in_h  = s_axis_tdata[2*COORD_BITS+RAD_BITS +: RAD_BITS];
	assign in_cx = s_axis_tdata[2*COORD_BITS+2*RAD_BITS +: COORD_BITS];
	assign in_cy = s_axis_tdata[3*COORD_BITS+2*RAD_BITS +: COORD_BITS];
	assign in_r  = s_axis_tdata[4*COORD_BITS+2*RAD_BITS +: RAD_BITS];
	assign in_m  = s_axis_tdata[4*COORD_BITS+3*RAD_BITS +: 4];

	// Valid bits and the back-pressure chain.
	logic               v_s1, v_s2, v_s3, v_out_q;
	logic [RAD_BITS-1:0] v_s4;
	logic               rdy1, rdy2, rdy3, rdy_out;
	logic [RAD_BITS-1:0] rdy4;

	assign rdy_out = !v_out_q || m_axis_tready;
	assign rdy4[RAD_BITS-1] = !v_s4[RAD_BITS-1] || rdy_out;
	genvar g;
	generate
		for (g = 0; g < RAD_BITS - 1; g++) begin : g_rdy
			assign rdy4[g] = !v_s4[g] || rdy4[g+1];
		end
	endgenerate
	assign rdy3 = !v_s3 || rdy4[0];
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	// Stage 1: register the fields and form the absolute distances.
	work_t      bx_s1, by_s1, cx_s1, cy_s1, dx_s1, dy_s1;
	rad_t       w_s1, h_s1, r_s1;
	logic [3:0] m_s1;
	logic       bgtx_s1, bgty_s1, cgtx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		work_t bx, by, cx, cy;
		bx = work_t'(in_bx);
		by = work_t'(in_by);
		cx = work_t'(in_cx);
		cy = work_t'(in_cy);
		if (rdy1) begin
			bx_s1   <= bx;
			by_s1   <= by;
			cx_s1   <= cx;
			cy_s1   <= cy;
			dx_s1   <= (cx > bx) ? cx - bx : bx - cx;
			dy_s1   <= (cy > by) ? cy - by : by - cy;
			w_s1    <= in_w;
			h_s1    <= in_h;
			r_s1    <= in_r;
			m_s1    <= in_m;
			bgtx_s1 <= bx > cx;
			bgty_s1 <= by > cy;
			cgtx_s1 <= cx > bx;
		end
	end

	// Stage 2: overlap tests, push targets, side costs and the small squares.
	work_t      bx_s2, by_s2, cx_s2, cy_s2;
	work_t      pxl_s2, pxr_s2, pyt_s2, pyb_s2;
	work_t      cost_s2 [4];
	rad_t       w_s2, h_s2;
	logic [3:0] m_s2;
	logic       near_s2, edge_s2, vert_s2, bgtx_s2, bgty_s2, cgtx_s2;
	logic [SQ_BITS-2:0] sxx_s2, syy_s2, rr_s2, ax_s2, ay_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		work_t w, h, r, wr, hr;
		rad_t  dx2, dy2;
		w   = work_t'(w_s1);
		h   = work_t'(h_s1);
		r   = work_t'(r_s1);
		wr  = w + r;
		hr  = h + r;
		dx2 = RAD_BITS'(dx_s1 - w);
		dy2 = RAD_BITS'(dy_s1 - h);
		if (rdy2) begin
			bx_s2      <= bx_s1;
			by_s2      <= by_s1;
			cx_s2      <= cx_s1;
			cy_s2      <= cy_s1;
			pxl_s2     <= bx_s1 - wr - work_t'(1);
			pxr_s2     <= bx_s1 + wr + work_t'(1);
			pyt_s2     <= by_s1 - hr - work_t'(1);
			pyb_s2     <= by_s1 + hr + work_t'(1);
			cost_s2[0] <= bgtx_s1 ? wr - dx_s1 : wr + dx_s1;
			cost_s2[1] <= bgtx_s1 ? wr + dx_s1 : wr - dx_s1;
			cost_s2[2] <= bgty_s1 ? hr - dy_s1 : hr + dy_s1;
			cost_s2[3] <= bgty_s1 ? hr + dy_s1 : hr - dy_s1;
			near_s2    <= (m_s1 != 4'h0) && (dx_s1 <= wr) && (dy_s1 <= hr);
			edge_s2    <= (dx_s1 <= w) || (dy_s1 <= h);
			vert_s2    <= (w - dx_s1) > (h - dy_s1);
			w_s2       <= w_s1;
			h_s2       <= h_s1;
			m_s2       <= m_s1;
			bgtx_s2    <= bgtx_s1;
			bgty_s2    <= bgty_s1;
			cgtx_s2    <= cgtx_s1;
			sxx_s2     <= dx2 * dx2;
			syy_s2     <= dy2 * dy2;
			rr_s2      <= r_s1 * r_s1;
			ax_s2      <= r_s1 * dx2;
			ay_s2      <= r_s1 * dy2;
		end
	end

	// Stage 3: side choice for edge overlaps and corner fallbacks, the
	// corner reach test and the squared numerators of the root quotient.
	ctx_t                ctx_s3;
	logic [SQ_BITS-1:0]  s_s3;
	logic [NUM_BITS-1:0] nx_s3, ny_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic [SQ_BITS-1:0] s;
		logic               corner_hit, both, found, hit;
		logic [1:0]         best;
		work_t              nx, ny;
		s = SQ_BITS'(sxx_s2) + SQ_BITS'(syy_s2);
		corner_hit = s <= SQ_BITS'(rr_s2);
		hit = near_s2 && (edge_s2 || corner_hit);
		both = m_s2[cgtx_s2 ? DIR_RIGHT : DIR_LEFT] && m_s2[bgty_s2 ? DIR_TOP : DIR_BOTTOM];
		nx = cx_s2;
		ny = cy_s2;
		found = 1'b0;
		best = 2'(DIR_LEFT);
		for (int i = 0; i < 4; i++) begin
			if (m_s2[i] && (!found || cost_s2[i] < cost_s2[best])) begin
				best  = 2'(i);
				found = 1'b1;
			end
		end
		if (edge_s2) begin
			if (m_s2 == 4'hF) begin
				if (vert_s2) begin
					ny = bgty_s2 ? pyt_s2 : pyb_s2;
				end else begin
					nx = bgtx_s2 ? pxl_s2 : pxr_s2;
				end
			end else begin
				case (best)
					2'(DIR_LEFT):  nx = pxl_s2;
					2'(DIR_RIGHT): nx = pxr_s2;
					2'(DIR_TOP):   ny = pyt_s2;
					default:       ny = pyb_s2;
				endcase
			end
		end else if (m_s2[cgtx_s2 ? DIR_RIGHT : DIR_LEFT]) begin
			// The vertical side is forbidden: push sideways only.
			nx = cgtx_s2 ? pxr_s2 : pxl_s2;
		end else begin
			// The horizontal side is forbidden: push vertically, even when
			// the mask does not list that side either.
			ny = bgty_s2 ? pyt_s2 : pyb_s2;
		end
		// Without a hit the circle stays where it was.
		if (!hit) begin
			nx = cx_s2;
			ny = cy_s2;
		end
		if (rdy3) begin
			ctx_s3.hit   <= hit;
			ctx_s3.diag  <= near_s2 && !edge_s2 && corner_hit && both;
			ctx_s3.right <= cgtx_s2;
			ctx_s3.top   <= bgty_s2;
			ctx_s3.nx    <= nx;
			ctx_s3.ny    <= ny;
			ctx_s3.bx    <= bx_s2;
			ctx_s3.by    <= by_s2;
			ctx_s3.w     <= w_s2;
			ctx_s3.h     <= h_s2;
			s_s3         <= s;
			nx_s3        <= ax_s2 * ax_s2;
			ny_s3        <= ay_s2 * ay_s2;
		end
	end

	// Stages 4 onward: one quotient bit per stage, most significant first.
	// Each stage finds the largest q with q*q*S <= N while keeping q*q*S
	// and q*S as running sums, so a trial needs only shifts and adds.
	ctx_t                ctx_s4 [RAD_BITS];
	logic [SQ_BITS-1:0]  s_s4   [RAD_BITS];
	logic [NUM_BITS-1:0] nx_s4  [RAD_BITS];
	logic [NUM_BITS-1:0] ny_s4  [RAD_BITS];
	logic [ACC_BITS-1:0] tx_s4  [RAD_BITS];
	logic [ACC_BITS-1:0] ty_s4  [RAD_BITS];
	logic [PRD_BITS-1:0] ux_s4  [RAD_BITS];
	logic [PRD_BITS-1:0] uy_s4  [RAD_BITS];
	rad_t                qx_s4  [RAD_BITS];
	rad_t                qy_s4  [RAD_BITS];

	generate
		for (g = 0; g < RAD_BITS; g++) begin : g_root
			localparam int B = RAD_BITS - 1 - g;

			ctx_t                p_ctx;
			logic [SQ_BITS-1:0]  p_s;
			logic [NUM_BITS-1:0] p_nx, p_ny;
			logic [ACC_BITS-1:0] p_tx, p_ty, c_tx, c_ty;
			logic [PRD_BITS-1:0] p_ux, p_uy;
			rad_t                p_qx, p_qy;
			logic                p_v, take_x, take_y;

			if (g == 0) begin : g_first
				assign p_v   = v_s3;
				assign p_ctx = ctx_s3;
				assign p_s   = s_s3;
				assign p_nx  = nx_s3;
				assign p_ny  = ny_s3;
				assign p_tx  = '0;
				assign p_ty  = '0;
				assign p_ux  = '0;
				assign p_uy  = '0;
				assign p_qx  = '0;
				assign p_qy  = '0;
			end else begin : g_next
				assign p_v   = v_s4[g-1];
				assign p_ctx = ctx_s4[g-1];
				assign p_s   = s_s4[g-1];
				assign p_nx  = nx_s4[g-1];
				assign p_ny  = ny_s4[g-1];
				assign p_tx  = tx_s4[g-1];
				assign p_ty  = ty_s4[g-1];
				assign p_ux  = ux_s4[g-1];
				assign p_uy  = uy_s4[g-1];
				assign p_qx  = qx_s4[g-1];
				assign p_qy  = qy_s4[g-1];
			end

			// (q + 2^B)^2 * S = q^2*S + (q*S << (B+1)) + (S << 2B)
			assign c_tx = p_tx + (ACC_BITS'(p_ux) << (B + 1)) + (ACC_BITS'(p_s) << (2 * B));
			assign c_ty = p_ty + (ACC_BITS'(p_uy) << (B + 1)) + (ACC_BITS'(p_s) << (2 * B));
			assign take_x = c_tx <= ACC_BITS'(p_nx);
			assign take_y = c_ty <= ACC_BITS'(p_ny);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s4[g] <= 1'b0;
				end else if (rdy4[g]) begin
					v_s4[g] <= p_v;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy4[g]) begin
					ctx_s4[g] <= p_ctx;
					s_s4[g]   <= p_s;
					nx_s4[g]  <= p_nx;
					ny_s4[g]  <= p_ny;
					tx_s4[g]  <= take_x ? c_tx : p_tx;
					ty_s4[g]  <= take_y ? c_ty : p_ty;
					ux_s4[g]  <= take_x ? p_ux + (PRD_BITS'(p_s) << B) : p_ux;
					uy_s4[g]  <= take_y ? p_uy + (PRD_BITS'(p_s) << B) : p_uy;
					qx_s4[g]  <= p_qx | (rad_t'(take_x) << B);
					qy_s4[g]  <= p_qy | (rad_t'(take_y) << B);
				end
			end
		end
	endgenerate

	// Output register: place the circle off the corner where that applies.
	logic                hit_q;
	logic [OUT_BITS-1:0] new_x_q, new_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (rdy_out) begin
			v_out_q <= v_s4[RAD_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		ctx_t  c;
		work_t ix, iy, nx, ny;
		c  = ctx_s4[RAD_BITS-1];
		ix = work_t'(c.w) + work_t'(qx_s4[RAD_BITS-1]) + work_t'(1);
		iy = work_t'(c.h) + work_t'(qy_s4[RAD_BITS-1]) + work_t'(1);
		nx = c.nx;
		ny = c.ny;
		if (c.diag) begin
			nx = c.right ? c.bx + ix : c.bx - ix;
			ny = c.top ? c.by - iy : c.by + iy;
		end
		if (rdy_out) begin
			hit_q   <= c.hit;
			new_x_q <= nx[OUT_BITS-1:0];
			new_y_q <= ny[OUT_BITS-1:0];
		end
	end

	assign m_axis_tvalid = v_out_q;
	assign m_axis_tuser  = hit_q;
	assign m_axis_tdata  = OUT_DBITS'({new_y_q, new_x_q});

endmodule
`default_nettype wire

// ===== tb/tb_circle_box_push_out_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_circle_box_push_out_unit;
	import cbpo_pkg::*;

	// One box/circle pair as it travels on the slave side.
	typedef struct {
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] by;
		logic [RAD_BITS-1:0]          w;
		logic [RAD_BITS-1:0]          h;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [RAD_BITS-1:0]          r;
		logic [3:0]                   mask;
	} pair_t;

	// One resolved position as it leaves on the master side.
	typedef struct {
		logic                       hit;
		logic signed [OUT_BITS-1:0] nx;
		logic signed [OUT_BITS-1:0] ny;
	} placed_t;

	localparam int  LIMIT_CYCLES = 400000;
	localparam int  DRAIN_CYCLES = 60;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_BITS-1:0]   s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_DBITS-1:0] m_axis_tdata;
	logic                 m_axis_tuser;

	pair_t   pending_pairs[$];
	placed_t expected_places[$];
	int      mismatches = 0;
	int      cycle_count = 0;
	bit      stimulus_done = 1'b0;
	// The receiver holds off while this is nonzero.
	int      hold_off = 0;
	// Cycle windows in which neither side idles.
	bit      steady_tx = 1'b0;
	bit      steady_rx = 1'b0;
	// Set when the slave side took a beat at the last rising edge.
	logic    s_axis_tready_seen = 1'b0;

	circle_box_push_out_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Largest q in [0, lim] with q*q*den <= num, found by bisection.
	function automatic longint unsigned root_quot(longint unsigned num, longint unsigned den,
			longint unsigned lim);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = lim;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (mid * mid * den <= num)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	// Works out where the circle ends up for one pair.
	function automatic placed_t resolve_push(pair_t p);
		placed_t res;
		longint bx, by, w, h, cx, cy, r, nx, ny, dx, dy, pl, pr, pt, pb;
		longint dx2, dy2, ix, iy, best_cost;
		longint cost[4];
		longint unsigned s, ax, ay;
		int best;
		bit hs_right, vs_top, h_ok, v_ok;
		bx = p.bx; by = p.by; cx = p.cx; cy = p.cy;
		w = p.w; h = p.h; r = p.r;
		nx = cx;
		ny = cy;
		res.hit = 1'b0;
		dx = (cx > bx) ? cx - bx : bx - cx;
		dy = (cy > by) ? cy - by : by - cy;
		pl = bx - w - r - 1;
		pr = bx + w + r + 1;
		pt = by - h - r - 1;
		pb = by + h + r + 1;
		if (p.mask != 4'd0 && dx <= w + r && dy <= h + r) begin
			if (dx <= w || dy <= h) begin
				res.hit = 1'b1;
				if (p.mask == 4'hF) begin
					if (w - dx > h - dy)
						ny = (by > cy) ? pt : pb;
					else
						nx = (bx > cx) ? pl : pr;
				end else begin
					cost[DIR_LEFT]   = w + r + ((bx > cx) ? -dx : dx);
					cost[DIR_RIGHT]  = w + r + ((bx > cx) ? dx : -dx);
					cost[DIR_TOP]    = h + r + ((by > cy) ? -dy : dy);
					cost[DIR_BOTTOM] = h + r + ((by > cy) ? dy : -dy);
					best = -1;
					best_cost = 0;
					for (int i = 0; i < 4; i++)
						if (p.mask[i] && (best < 0 || cost[i] < best_cost)) begin
							best = i;
							best_cost = cost[i];
						end
					case (best)
						DIR_LEFT:  nx = pl;
						DIR_RIGHT: nx = pr;
						DIR_TOP:   ny = pt;
						default:   ny = pb;
					endcase
				end
			end else begin
				dx2 = dx - w;
				dy2 = dy - h;
				s = dx2 * dx2 + dy2 * dy2;
				if (s <= r * r) begin
					ax = r * dx2;
					ay = r * dy2;
					ix = w + longint'(root_quot(ax * ax, s, r)) + 1;
					iy = h + longint'(root_quot(ay * ay, s, r)) + 1;
					hs_right = (bx < cx);
					vs_top = (by > cy);
					h_ok = hs_right ? p.mask[DIR_RIGHT] : p.mask[DIR_LEFT];
					v_ok = vs_top ? p.mask[DIR_TOP] : p.mask[DIR_BOTTOM];
					res.hit = 1'b1;
					if (h_ok && v_ok) begin
						nx = hs_right ? bx + ix : bx - ix;
						ny = vs_top ? by - iy : by + iy;
					end else if (h_ok)
						nx = hs_right ? pr : pl;
					else
						ny = vs_top ? pt : pb;
				end
			end
		end
		res.nx = nx[OUT_BITS-1:0];
		res.ny = ny[OUT_BITS-1:0];
		return res;
	endfunction

	function automatic logic [IN_BITS-1:0] pack_pair(pair_t p);
		logic [IN_BITS-1:0] v;
		v = '0;
		v[IN_RAW-1:0] = {p.mask, p.r, p.cy, p.cx, p.h, p.w, p.by, p.bx};
		return v;
	endfunction

	function automatic pair_t make_pair(int bx, int by, int w, int h, int cx, int cy, int r,
			int mask);
		pair_t p;
		p.bx = COORD_BITS'(bx); p.by = COORD_BITS'(by);
		p.w = RAD_BITS'(w); p.h = RAD_BITS'(h);
		p.cx = COORD_BITS'(cx); p.cy = COORD_BITS'(cy);
		p.r = RAD_BITS'(r); p.mask = 4'(mask);
		return p;
	endfunction

	// A pair whose circle lies close to the box, so that hits, corners and
	// misses all turn up often. Sizes are mostly small, now and then full.
	function automatic pair_t near_pair();
		pair_t p;
		int span;
		p.bx = COORD_BITS'($urandom);
		p.by = COORD_BITS'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			p.w = RAD_BITS'($urandom); p.h = RAD_BITS'($urandom); p.r = RAD_BITS'($urandom);
		end else begin
			p.w = RAD_BITS'($urandom_range(0, 200));
			p.h = RAD_BITS'($urandom_range(0, 200));
			p.r = RAD_BITS'($urandom_range(0, 200));
		end
		span = p.w + p.h + 2 * p.r + 4;
		p.cx = COORD_BITS'(p.bx + $signed($urandom_range(0, 2 * span)) - span);
		p.cy = COORD_BITS'(p.by + $signed($urandom_range(0, 2 * span)) - span);
		p.mask = ($urandom_range(0, 2) == 0) ? 4'hF : 4'($urandom);
		return p;
	endfunction

	function automatic pair_t wild_pair();
		pair_t p;
		p.bx = COORD_BITS'($urandom); p.by = COORD_BITS'($urandom);
		p.w = RAD_BITS'($urandom); p.h = RAD_BITS'($urandom);
		p.cx = COORD_BITS'($urandom); p.cy = COORD_BITS'($urandom);
		p.r = RAD_BITS'($urandom); p.mask = 4'($urandom);
		return p;
	endfunction

	initial begin
		// Directed pairs: misses, edge pushes on each side, ties, every mask
		// shape on a corner, the empty mask, and the field extremes.
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 100, 0, 5, 15));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 3, 1, 5, 15));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, -3, 1, 5, 15));
		pending_pairs.push_back(make_pair(0, 0, 20, 5, 1, 3, 5, 15));
		pending_pairs.push_back(make_pair(0, 0, 20, 5, 1, -3, 5, 15));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 0, 5, 0));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 0, 5, 1));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 0, 5, 2));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 0, 5, 4));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 0, 5, 8));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 0, 5, 12));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 13, 14, 10, 15));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, -13, -14, 10, 5));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 13, -14, 10, 2));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, -13, 14, 10, 8));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 13, 14, 10, 4));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 18, 18, 10, 15));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 17, 17, 10, 15));
		pending_pairs.push_back(make_pair(32767, 32767, 16383, 16383, -32768, -32768,
			16383, 15));
		pending_pairs.push_back(make_pair(-32768, -32768, 16383, 16383, 32767, 32767,
			16383, 15));
		pending_pairs.push_back(make_pair(32767, -32768, 16383, 0, 32767, -32768, 16383, 9));
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 15));
		pending_pairs.push_back(make_pair(-32768, 32767, 0, 16383, -1, 32767, 16383, 6));
		for (int i = 0; i < 1600; i++)
			pending_pairs.push_back(($urandom_range(0, 9) < 8) ? near_pair() : wild_pair());
	end

	// Idle-free windows come from the cycle count, so both sides run flat out
	// for a while early in the random part.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		steady_tx <= (cycle_count >= 600 && cycle_count < 1400);
		steady_rx <= (cycle_count >= 600 && cycle_count < 1400);
	end

	// Driver: offers the next pair at the falling edge, holding it until taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tready_seen) begin
				expected_places.push_back(resolve_push(pending_pairs.pop_front()));
			end
			if (!s_axis_tvalid || s_axis_tready_seen) begin
				if (pending_pairs.size() > 0 && (steady_tx || $urandom_range(0, 99) >= 38)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pack_pair(pending_pairs[0]);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			if (pending_pairs.size() == 0 && !s_axis_tvalid)
				stimulus_done <= 1'b1;
		end
	end

	// Handshake as sampled at the rising edge, so the driver knows whether
	// its beat went through.
	always @(posedge clk)
		s_axis_tready_seen <= s_axis_tvalid && s_axis_tready;

	// Receiver hold-off: one long stall that lets the pipeline fill and push
	// back on the sender, counted down here.
	always @(negedge clk) begin
		if (cycle_count == 300)
			hold_off <= 300;
		else if (hold_off > 0)
			hold_off <= hold_off - 1;
		m_axis_tready <= arst_n && hold_off == 0 && (steady_rx || $urandom_range(0, 99) >= 38);
	end

	// Monitor: checks every beat on the master side against the oldest
	// expectation.
	always @(posedge clk) begin
		placed_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_places.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result beat: hit %0b x %0d y %0d", m_axis_tuser,
						$signed(m_axis_tdata[OUT_BITS-1:0]),
						$signed(m_axis_tdata[2*OUT_BITS-1:OUT_BITS]));
			end else begin
				want = expected_places.pop_front();
				if (want.hit !== m_axis_tuser || want.nx !== m_axis_tdata[OUT_BITS-1:0] ||
						want.ny !== m_axis_tdata[2*OUT_BITS-1:OUT_BITS] ||
						m_axis_tdata[OUT_DBITS-1:2*OUT_BITS] !== '0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: expected hit %0b x %0d y %0d, got hit %0b x %0d y %0d",
							want.hit, want.nx, want.ny, m_axis_tuser,
							$signed(m_axis_tdata[OUT_BITS-1:0]),
							$signed(m_axis_tdata[2*OUT_BITS-1:OUT_BITS]));
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (stimulus_done && expected_places.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_places.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
src/cbpo_pkg.sv
src/circle_box_push_out_unit.sv
tb/tb_circle_box_push_out_unit.sv
